[src/ckl_pkg.sv]
// ckl_pkg: shared types, key codes and sizes for the keypad credential lock.
// No dependencies; imported by ckl_search, ckl_checker and the top level.
`timescale 1ns / 1ps

package ckl_pkg;

  // Default sizing
  localparam int unsigned DigitsDef     = 10;
  localparam int unsigned MaxRecordsDef = 16;

  // Fixed field widths of the request and result
  localparam int unsigned KeyW       = 8;
  localparam int unsigned StoreAddrW = 9;
  localparam int unsigned UserIdxW   = 4;

  // Key codes
  localparam logic [KeyW-1:0] KeyNone = 8'h00;
  localparam logic [KeyW-1:0] KeyA    = 8'h41;
  localparam logic [KeyW-1:0] KeyB    = 8'h42;
  localparam logic [KeyW-1:0] KeyC    = 8'h43;
  localparam logic [KeyW-1:0] KeyD    = 8'h44;
  localparam logic [KeyW-1:0] KeyStar = 8'h2A;
  localparam logic [KeyW-1:0] KeyHash = 8'h23;
  localparam logic [KeyW-1:0] KeyEnd  = 8'h78;  // 'x' ends the record table

  // Display actions
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_SHOW   = 3'd1,
    ACT_CLEAR  = 3'd2,
    ACT_ADMIN  = 3'd3,
    ACT_USER   = 3'd4,
    ACT_DENIED = 3'd5
  } disp_act_e;

  // Request functions
  typedef enum logic {
    FUNC_KEY   = 1'b0,
    FUNC_WRITE = 1'b1
  } func_e;

  // Entry phases
  typedef enum logic {
    PH_ID  = 1'b0,
    PH_PIN = 1'b1
  } phase_e;

  // Top-level sequencer
  typedef enum logic {
    TS_IDLE,
    TS_SEARCH
  } top_state_e;

  // Search sequencer
  typedef enum logic {
    SR_IDLE,
    SR_RUN
  } srch_state_e;

  // Verdict from the search unit
  typedef struct packed {
    logic                done;
    logic                hit;
    logic                admin;
    logic [UserIdxW-1:0] user_index;
  } srch_res_t;

endpackage

[src/ckl_ram.sv]
// ckl_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ckl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 320
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/ckl_search.sv]
// ckl_search: record search sequencer with one shared byte comparator.
// Depends on ckl_pkg; reads the credential store through ckl_ram.
`timescale 1ns / 1ps

module ckl_search
  import ckl_pkg::*;
#(
  parameter int unsigned DIGITS      = DigitsDef,
  parameter int unsigned MAX_RECORDS = MaxRecordsDef,
  localparam int unsigned RecBytes   = 2 * DIGITS,
  localparam int unsigned StoreBytes = MAX_RECORDS * RecBytes,
  localparam int unsigned AddrW      = $clog2(StoreBytes),
  localparam int unsigned ByteW      = $clog2(RecBytes)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KeyW-1:0]  want_i,     // entered byte at cmp_byte_o
  input  logic [KeyW-1:0]  rd_data_i,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  output logic [ByteW-1:0] cmp_byte_o,
  output srch_res_t        res_o
);

  localparam int unsigned RecW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

  srch_state_e      state_q, state_d;
  logic             iss_on_q, iss_on_d;
  logic [AddrW-1:0] iss_addr_q, iss_addr_d;
  logic [ByteW-1:0] iss_byte_q, iss_byte_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [ByteW-1:0] cmp_byte_q, cmp_byte_d;
  logic [RecW-1:0]  cmp_rec_q, cmp_rec_d;
  logic             same_q, same_d;

  logic byte_eq, end_mark, last_byte, last_rec, same_all;
  logic done, hit;

  // Comparator and record bookkeeping
  assign byte_eq   = (rd_data_i == want_i);
  assign end_mark  = (cmp_byte_q == '0) && (rd_data_i == KeyEnd);
  assign last_byte = (cmp_byte_q == ByteW'(RecBytes - 1));
  assign last_rec  = (cmp_rec_q == RecW'(MAX_RECORDS - 1));
  assign same_all  = same_q & byte_eq;

  always_comb begin
    done = 1'b0;
    hit  = 1'b0;
    if (state_q == SR_RUN && cmp_vld_q) begin
      if (end_mark) begin
        done = 1'b1;
      end else if (last_byte && same_all) begin
        done = 1'b1;
        hit  = 1'b1;
      end else if (last_byte && last_rec) begin
        done = 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SR_IDLE: if (start_i) state_d = SR_RUN;
      SR_RUN:  if (done) state_d = SR_IDLE;
      default: state_d = SR_IDLE;
    endcase
  end

  // Issue and compare pipeline
  always_comb begin
    iss_on_d   = iss_on_q;
    iss_addr_d = iss_addr_q;
    iss_byte_d = iss_byte_q;
    cmp_vld_d  = 1'b0;
    cmp_byte_d = iss_byte_q;
    cmp_rec_d  = cmp_rec_q;
    same_d     = same_q;
    case (state_q)
      SR_IDLE: begin
        if (start_i) begin
          iss_on_d   = 1'b1;
          iss_addr_d = '0;
          iss_byte_d = '0;
          cmp_rec_d  = '0;
          same_d     = 1'b1;
        end
      end
      SR_RUN: begin
        // address side
        if (iss_on_q) begin
          cmp_vld_d  = 1'b1;
          iss_addr_d = iss_addr_q + AddrW'(1);
          iss_byte_d = (iss_byte_q == ByteW'(RecBytes - 1)) ? '0 : iss_byte_q + ByteW'(1);
          if (iss_addr_q == AddrW'(StoreBytes - 1)) begin
            iss_on_d = 1'b0;
          end
        end
        // compare side
        if (cmp_vld_q) begin
          if (last_byte) begin
            cmp_rec_d = cmp_rec_q + RecW'(1);
            same_d    = 1'b1;
          end else begin
            same_d = same_all;
          end
        end
        if (done) begin
          iss_on_d  = 1'b0;
          cmp_vld_d = 1'b0;
        end
      end
      default: begin
        iss_on_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SR_IDLE;
      iss_on_q  <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_on_q  <= iss_on_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_addr_q <= iss_addr_d;
    iss_byte_q <= iss_byte_d;
    cmp_byte_q <= cmp_byte_d;
    cmp_rec_q  <= cmp_rec_d;
    same_q     <= same_d;
  end

  // Outputs
  assign rd_en_o    = (state_q == SR_RUN) && iss_on_q;
  assign rd_addr_o  = iss_addr_q;
  assign cmp_byte_o = cmp_byte_q;

  always_comb begin
    res_o            = '0;
    res_o.done       = done;
    res_o.hit        = hit;
    res_o.admin      = hit && (cmp_rec_q == '0);
    res_o.user_index = hit ? UserIdxW'(cmp_rec_q) : '0;
  end

endmodule

[src/keypad_credential_lock_top.sv]
// A write, or a key press other than 'A' in PIN entry, gives its result in the cycle after the request is taken.
// 'A' in PIN entry searches the store one byte a cycle through a single RAM read port;
// when no record matches and no end mark, it reads all MAX_RECORDS*2*DIGITS bytes (320 at the defaults).
// One request at a time; no new request is taken while a search runs.
// Reset clears phase, digit counts and handshake state; the store is not cleared.
`timescale 1ns / 1ps

module keypad_credential_lock_top
  import ckl_pkg::*;
#(
  parameter int unsigned DIGITS      = DigitsDef,
  parameter int unsigned MAX_RECORDS = MaxRecordsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic [KeyW-1:0]       key_code_i,
  input  logic [StoreAddrW-1:0] store_addr_i,
  input  logic [KeyW-1:0]       store_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  phase_o,
  output logic [2:0]            display_action_o,
  output logic [KeyW-1:0]       display_char_o,
  output logic [UserIdxW-1:0]   user_index_o
);

  localparam int unsigned RecBytes   = 2 * DIGITS;
  localparam int unsigned StoreBytes = MAX_RECORDS * RecBytes;
  localparam int unsigned AddrW      = $clog2(StoreBytes);
  localparam int unsigned ByteW      = $clog2(RecBytes);
  localparam int unsigned DigW       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned CntW       = $clog2(DIGITS + 1);

  top_state_e          state_q, state_d;
  phase_e              phase_q, phase_d;
  logic [CntW-1:0]     id_cnt_q, id_cnt_d, pin_cnt_q, pin_cnt_d;
  logic [KeyW-1:0]     id_dig_q  [DIGITS];
  logic [KeyW-1:0]     pin_dig_q [DIGITS];
  logic                id_we, pin_we;

  logic                out_vld_q, out_vld_d;
  logic                out_load;
  phase_e              out_phase_d, out_phase_q;
  disp_act_e           out_act_d, out_act_q;
  logic [KeyW-1:0]     out_char_d, out_char_q;
  logic [UserIdxW-1:0] out_uidx_d, out_uidx_q;

  logic                accept, srch_start;
  logic                st_we;
  logic [AddrW-1:0]    st_waddr;
  logic                rd_en;
  logic [AddrW-1:0]    rd_addr;
  logic [KeyW-1:0]     rd_data;
  logic [ByteW-1:0]    cmp_byte;
  logic [ByteW-1:0]    pin_byte;
  logic [DigW-1:0]     id_idx, pin_idx;
  logic [KeyW-1:0]     want;
  srch_res_t           srch_res;

  // Handshake
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != TS_IDLE) || (out_vld_q && out_stall_i);

  // Store write
  assign st_we    = accept && (func_i == FUNC_WRITE)
                    && (32'(store_addr_i) < 32'(StoreBytes));
  assign st_waddr = AddrW'(store_addr_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      TS_IDLE:   if (srch_start) state_d = TS_SEARCH;
      TS_SEARCH: if (srch_res.done) state_d = TS_IDLE;
      default:   state_d = TS_IDLE;
    endcase
  end

  // Key decode, buffer update and result
  always_comb begin
    phase_d     = phase_q;
    id_cnt_d    = id_cnt_q;
    pin_cnt_d   = pin_cnt_q;
    id_we       = 1'b0;
    pin_we      = 1'b0;
    srch_start  = 1'b0;
    out_load    = 1'b0;
    out_act_d   = ACT_NONE;
    out_char_d  = '0;
    out_uidx_d  = '0;
    case (state_q)
      TS_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          if (func_i == FUNC_KEY) begin
            case (key_code_i)
              KeyNone, KeyB, KeyC, KeyD, KeyHash: ;
              KeyStar: begin
                if (phase_q == PH_ID) id_cnt_d = '0;
                else                  pin_cnt_d = '0;
                out_act_d = ACT_CLEAR;
              end
              KeyA: begin
                if (phase_q == PH_ID) begin
                  phase_d   = PH_PIN;
                  out_act_d = ACT_CLEAR;
                end else begin
                  srch_start = 1'b1;
                  out_load   = 1'b0;
                end
              end
              default: begin
                if (phase_q == PH_ID) begin
                  if (id_cnt_q < CntW'(DIGITS)) begin
                    id_we      = 1'b1;
                    id_cnt_d   = id_cnt_q + CntW'(1);
                    out_act_d  = ACT_SHOW;
                    out_char_d = key_code_i;
                  end
                end else begin
                  if (pin_cnt_q < CntW'(DIGITS)) begin
                    pin_we     = 1'b1;
                    pin_cnt_d  = pin_cnt_q + CntW'(1);
                    out_act_d  = ACT_SHOW;
                    out_char_d = KeyStar;
                  end
                end
              end
            endcase
          end
        end
      end
      TS_SEARCH: begin
        if (srch_res.done) begin
          out_load  = 1'b1;
          phase_d   = PH_ID;
          id_cnt_d  = '0;
          pin_cnt_d = '0;
          if (!srch_res.hit)      out_act_d = ACT_DENIED;
          else if (srch_res.admin) out_act_d = ACT_ADMIN;
          else                    out_act_d = ACT_USER;
          out_uidx_d = srch_res.user_index;
        end
      end
      default: ;
    endcase
    out_phase_d = phase_d;
  end

  // Output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && !out_stall_i) out_vld_d = 1'b0;
    if (out_load) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= TS_IDLE;
      phase_q   <= PH_ID;
      id_cnt_q  <= '0;
      pin_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      id_cnt_q  <= id_cnt_d;
      pin_cnt_q <= pin_cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_phase_q <= out_phase_d;
      out_act_q   <= out_act_d;
      out_char_q  <= out_char_d;
      out_uidx_q  <= out_uidx_d;
    end
  end

  // Digit buffers; entries past the count read as zero padding
  always_ff @(posedge clk_i) begin
    if (id_we)  id_dig_q[id_cnt_q[DigW-1:0]]   <= key_code_i;
    if (pin_we) pin_dig_q[pin_cnt_q[DigW-1:0]] <= key_code_i;
  end

  // Entered byte for the comparator: ID digits, then PIN digits
  assign pin_byte = cmp_byte - ByteW'(DIGITS);
  assign id_idx   = cmp_byte[DigW-1:0];
  assign pin_idx  = pin_byte[DigW-1:0];

  always_comb begin
    want = '0;
    if (cmp_byte < ByteW'(DIGITS)) begin
      if (CntW'(id_idx) < id_cnt_q) want = id_dig_q[id_idx];
    end else begin
      if (CntW'(pin_idx) < pin_cnt_q) want = pin_dig_q[pin_idx];
    end
  end

  ckl_ram #(
    .WIDTH (KeyW),
    .DEPTH (StoreBytes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (store_data_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  ckl_search #(
    .DIGITS      (DIGITS),
    .MAX_RECORDS (MAX_RECORDS)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (srch_start),
    .want_i     (want),
    .rd_data_i  (rd_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .cmp_byte_o (cmp_byte),
    .res_o      (srch_res)
  );

  assign out_valid_o      = out_vld_q;
  assign phase_o          = out_phase_q;
  assign display_action_o = out_act_q;
  assign display_char_o   = out_char_q;
  assign user_index_o     = out_uidx_q;

endmodule

[src/ckl_checker.sv]
// ckl_checker: port-level checks on the keypad credential lock results.
// Depends on ckl_pkg; bound to keypad_credential_lock_top below.
`timescale 1ns / 1ps

module ckl_checker
  import ckl_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic                  phase_o,
  input logic [2:0]            display_action_o,
  input logic [KeyW-1:0]       display_char_o,
  input logic [UserIdxW-1:0]   user_index_o
);

  logic verdict;
  assign verdict = (display_action_o == ACT_ADMIN) || (display_action_o == ACT_USER)
                   || (display_action_o == ACT_DENIED);

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(display_action_o)
      && $stable(display_char_o) && $stable(user_index_o) && $stable(phase_o))
    else $error("stalled result changed");

  // Every verdict sends the lock back to ID entry
  a_verdict_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict |-> phase_o == PH_ID)
    else $error("verdict left lock in PIN entry");

  // A character only comes with a show action
  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (display_action_o != ACT_SHOW) |-> display_char_o == '0)
    else $error("character without show action");

  // Record index only for a user grant; admin is record zero
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (display_action_o != ACT_USER) |-> user_index_o == '0)
    else $error("record index outside user grant");

  // A PIN echo is always masked and only happens in PIN entry
  a_pin_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (display_action_o == ACT_SHOW) && (phase_o == PH_PIN)
      |-> display_char_o == KeyStar)
    else $error("PIN digit echoed in clear");

endmodule

bind keypad_credential_lock_top ckl_checker u_ckl_checker (.*);
